/* rtl/core/hsd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hex sensor deframer package
// Shared types, frame constants and the ASCII hex digit decoder.
// ----------------------------------------------------------------------------
package hsd_pkg;

	// Frame layout: six 4-digit readings followed by a 2-digit checksum.
	localparam int unsigned FRAME_CHARS   = 26;
	localparam int unsigned READING_CHARS = 24;
	localparam int unsigned NUM_READINGS  = 6;
	localparam int unsigned READING_W     = 16;
	localparam int unsigned BYTE_W        = 8;
	localparam int unsigned POS_W         = 5;
	localparam int unsigned IDX_W         = 3;

	localparam logic [POS_W-1:0] LAST_POS     = POS_W'(FRAME_CHARS - 1);
	localparam logic [POS_W-1:0] READINGS_END = POS_W'(READING_CHARS);

	typedef logic [READING_W-1:0] reading_t;

	// Frame status codes.
	typedef enum logic [1:0] {
		ST_GOOD     = 2'd0,
		ST_CSUM_ERR = 2'd1,
		ST_BAD_CHAR = 2'd2
	} frame_status_t;

	// One received word as held in the input register.
	typedef struct packed {
		logic              restart;
		logic [BYTE_W-1:0] rx_byte;
	} item_t;

	// One finished frame.
	typedef struct packed {
		reading_t [NUM_READINGS-1:0] readings;
		frame_status_t               status;
	} result_t;

	// Decoded character.
	typedef struct packed {
		logic       is_hex;
		logic [3:0] value;
	} hex_digit_t;

	// Map an ASCII character to its hex value; non-hex characters give value zero.
	function automatic hex_digit_t hex_decode(input logic [BYTE_W-1:0] c);
		hex_digit_t r;
		r.is_hex = 1'b1;
		r.value  = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.value = c[3:0];
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			r.value = c[3:0] + 4'd9;
		end else begin
			r.is_hex = 1'b0;
		end
		return r;
	endfunction

endpackage : hsd_pkg
`default_nettype wire

/* rtl/core/hex_sensor_frame_deframer.sv */
`timescale 1ns / 1ps
`default_nettype none
// A frame result is registered as its 26th character word leaves the input register.
// Throughput: one character word per cycle while the output is not stalled; the input
// register and the result register are the only stages around a single frame core.
// Reset: arst_n clears the position, accumulator, checksum and both valid flags at once;
// the reading store is not cleared, since each frame rewrites all six readings.
// ----------------------------------------------------------------------------
// Hex sensor frame deframer
// Decodes 26-character ASCII hex frames into six 16-bit readings and a status.
// ----------------------------------------------------------------------------
module hex_sensor_frame_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  wire logic [0:0]  s_axis_tuser,   // [0] restart
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [95:0]      m_axis_tdata,   // ir_zone1, us_zone1, ir_zone2,
	                                         // us_zone2, ir_zone3, us_zone3
	output logic [1:0]       m_axis_tuser    // [1:0] frame_status
);
	import hsd_pkg::*;

	item_t   in_item;
	item_t   item_s1;
	logic    item_fire;
	logic    advance;
	logic    result_valid;
	result_t result;
	result_t result_q;
	logic    out_valid_q;

	assign in_item.restart = s_axis_tuser[0];
	assign in_item.rx_byte = s_axis_tdata;

	// The core moves on whenever the result register is free or being drained.
	assign advance = ~out_valid_q | m_axis_tready;

	hsd_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_item   (in_item),
		.advance   (advance),
		.item_fire (item_fire),
		.item_s1   (item_s1)
	);

	hsd_frame_core u_frame_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_fire    (item_fire),
		.item_s1      (item_s1),
		.result_valid (result_valid),
		.result       (result)
	);

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (result_valid) begin
			result_q <= result;
		end
	end

	// Output word: first reading in the lowest bits.
	always_comb begin
		m_axis_tvalid = out_valid_q;
		for (int i = 0; i < NUM_READINGS; i++) begin
			m_axis_tdata[i*READING_W +: READING_W] = result_q.readings[i];
		end
		m_axis_tuser = result_q.status;
	end

endmodule : hex_sensor_frame_deframer
`default_nettype wire

/* rtl/core/hsd_in_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hex sensor deframer input stage
// Registers one incoming word and hands it on when the frame core advances.
// ----------------------------------------------------------------------------
module hsd_in_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire hsd_pkg::item_t in_item,
	input  wire logic          advance,
	output logic               item_fire,
	output hsd_pkg::item_t     item_s1
);
	import hsd_pkg::*;

	logic valid_s1;

	// The register takes a new word when empty or when its word moves on.
	assign item_fire = valid_s1 & advance;
	assign in_ready  = ~valid_s1 | advance;

	// Valid flag of the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (item_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload of the input register.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule : hsd_in_stage
`default_nettype wire

/* rtl/core/hsd_frame_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hex sensor deframer frame core
// Tracks the character position, assembles readings and checks the frame.
// ----------------------------------------------------------------------------
module hsd_frame_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_fire,
	input  wire hsd_pkg::item_t item_s1,
	output logic               result_valid,
	output hsd_pkg::result_t   result
);
	import hsd_pkg::*;

	logic [POS_W-1:0]     pos_q;
	reading_t             acc_q;
	logic [BYTE_W-1:0]    xor_q;
	logic                 bad_q;
	reading_t             store_q [NUM_READINGS];

	hex_digit_t           digit;
	reading_t             acc_shift;
	logic                 group_end;
	logic                 last_char;
	logic [IDX_W-1:0]     store_idx;
	logic [BYTE_W-1:0]    xor_final;
	logic                 bad_next;
	logic                 do_char;

	// Decode the character and shift it into the accumulator.
	always_comb begin
		digit     = hex_decode(item_s1.rx_byte);
		acc_shift = {acc_q[READING_W-5:0], digit.value};
		group_end = (pos_q < READINGS_END) && (pos_q[1:0] == 2'b11);
		last_char = (pos_q == LAST_POS);
		store_idx = pos_q[POS_W-1:2];
		xor_final = xor_q ^ acc_shift[BYTE_W-1:0];
		bad_next  = bad_q | ~digit.is_hex;
		do_char   = item_fire & ~item_s1.restart;
	end

	// Frame state: position, accumulator, running checksum and bad flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			acc_q <= '0;
			xor_q <= '0;
			bad_q <= 1'b0;
		end else if (item_fire) begin
			if (item_s1.restart || last_char) begin
				pos_q <= '0;
				acc_q <= '0;
				xor_q <= '0;
				bad_q <= 1'b0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
				bad_q <= bad_next;
				if (group_end) begin
					acc_q <= '0;
					xor_q <= xor_q ^ acc_shift[BYTE_W-1:0] ^ acc_shift[READING_W-1:BYTE_W];
				end else begin
					acc_q <= acc_shift;
				end
			end
		end
	end

	// Reading store: one register per reading, written as its group completes.
	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_READINGS; i++) begin
			if (do_char && group_end && store_idx == IDX_W'(i)) begin
				store_q[i] <= acc_shift;
			end
		end
	end

	// Result of the last character of a frame.
	always_comb begin
		result_valid = do_char & last_char;
		for (int i = 0; i < NUM_READINGS; i++) begin
			result.readings[i] = store_q[i];
		end
		if (bad_next) begin
			result.status = ST_BAD_CHAR;
		end else if (xor_final != '0) begin
			result.status = ST_CSUM_ERR;
		end else begin
			result.status = ST_GOOD;
		end
	end

endmodule : hsd_frame_core
`default_nettype wire

/* rtl/core/hsd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hex sensor deframer checker
// Port-level assertions on the deframer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module hsd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [95:0] m_axis_tdata,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [1:0]  m_axis_tuser
);
	// A stalled output word stays valid and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled output word changed");

	// A new result follows an input word that passed the input register and the result register.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result without a matching input word");

	// The status never carries the unused code.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser != 2'd3)
		else $error("unused frame status code");

	// With the result register empty the input side is always ready.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while output is empty");

endmodule : hsd_checker

bind hex_sensor_frame_deframer hsd_checker u_hsd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex sensor frame deframer testbench
// Streams ASCII hex frames, restarts, broken frames and noise words into the
// deframer with random gaps on both sides, predicts every frame result with a
// local decoder and compares each result word field by field.
// ----------------------------------------------------------------------------
module tb;
	import hsd_pkg::*;

	localparam int CLK_HALF    = 4;
	localparam int RESET_TICKS = 7;
	localparam int CHAR_TARGET = 1700;
	localparam int IDLE_LIMIT  = 4000;
	localparam int DRAIN_TICKS = 20;
	localparam int HOLD_TICKS  = 400;

	// Expected contents of one result word.
	typedef struct packed {
		reading_t [NUM_READINGS-1:0] readings;
		frame_status_t               status;
	} frame_rec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
	logic [0:0]  s_axis_tuser = 1'b0;    // [0] restart
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [95:0] m_axis_tdata;           // ir_zone1, us_zone1, ir_zone2,
	                                     // us_zone2, ir_zone3, us_zone3
	logic [1:0]  m_axis_tuser;           // [1:0] frame_status

	hex_sensor_frame_deframer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Stimulus and expectation stores.
	item_t      char_queue[$];
	frame_rec_t frames_due[$];
	int         error_count = 0;
	int         words_taken = 0;
	int         frames_seen = 0;
	logic       in_taken = 1'b0;

	// Local copy of the deframer state.
	int          cur_pos = 0;
	logic [15:0] digit_acc = '0;
	reading_t    reading_mem [NUM_READINGS];
	logic [7:0]  csum_acc = '0;
	logic        saw_bad = 1'b0;

	string zone_name [NUM_READINGS] = '{"ir_zone1", "us_zone1", "ir_zone2",
		"us_zone2", "ir_zone3", "us_zone3"};

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Hex value of an ASCII character, or -1 when it is not a hex digit.
	function automatic int nibble_of(logic [7:0] c);
		if (c inside {[8'h30:8'h39]}) return int'(c) - 'h30;
		if (c inside {[8'h41:8'h46]}) return int'(c) - 'h41 + 10;
		if (c inside {[8'h61:8'h66]}) return int'(c) - 'h61 + 10;
		return -1;
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
		if (n < 10) return 8'h30 + n;
		return (lower ? 8'h61 : 8'h41) + 8'(n - 4'd10);
	endfunction

	function automatic logic [7:0] random_non_hex();
		logic [7:0] c;
		c = 8'($urandom_range(255));
		while (nibble_of(c) >= 0) c = 8'($urandom_range(255));
		return c;
	endfunction

	// Apply one accepted word to the local state; a finished frame queues a result.
	task automatic deframe_char(logic restart, logic [7:0] ch);
		int         d;
		frame_rec_t rec;
		if (restart) begin
			cur_pos = 0;
			digit_acc = '0;
			csum_acc = '0;
			saw_bad = 1'b0;
			return;
		end
		d = nibble_of(ch);
		if (d < 0) begin
			saw_bad = 1'b1;
			d = 0;
		end
		digit_acc = {digit_acc[11:0], 4'(d)};
		if (cur_pos < READING_CHARS && cur_pos % 4 == 3) begin
			reading_mem[cur_pos / 4] = digit_acc;
			csum_acc ^= digit_acc[7:0] ^ digit_acc[15:8];
			digit_acc = '0;
		end
		if (cur_pos + 1 < FRAME_CHARS) begin
			cur_pos++;
			return;
		end
		// The accumulator now holds the checksum byte.
		csum_acc ^= digit_acc[7:0];
		for (int i = 0; i < NUM_READINGS; i++) rec.readings[i] = reading_mem[i];
		if (saw_bad) rec.status = ST_BAD_CHAR;
		else if (csum_acc != 0) rec.status = ST_CSUM_ERR;
		else rec.status = ST_GOOD;
		frames_due.push_back(rec);
		cur_pos = 0;
		digit_acc = '0;
		csum_acc = '0;
		saw_bad = 1'b0;
	endtask

	task automatic push_word(logic restart, logic [7:0] ch);
		item_t it;
		it.restart = restart;
		it.rx_byte = ch;
		char_queue.push_back(it);
	endtask

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++) push_word(1'b0, s[i]);
	endtask

	// One random frame: mostly well formed, sometimes with a wrong checksum,
	// non-hex characters, or cut short by a restart.
	task automatic push_random_frame();
		logic [7:0] chars [FRAME_CHARS];
		logic [15:0] r;
		logic [7:0] sum;
		int case_mode;
		int cut;
		sum = '0;
		case_mode = $urandom_range(2);
		for (int i = 0; i < NUM_READINGS; i++) begin
			case ($urandom_range(9))
				0: r = 16'h0000;
				1: r = 16'hffff;
				default: r = 16'($urandom_range(65535));
			endcase
			sum ^= r[7:0] ^ r[15:8];
			for (int k = 0; k < 4; k++) begin
				chars[4 * i + k] = hex_char(r[15 - 4 * k -: 4],
					case_mode == 2 ? bit'($urandom_range(1)) : bit'(case_mode));
			end
		end
		if ($urandom_range(99) < 20) sum ^= 8'($urandom_range(1, 255));
		chars[24] = hex_char(sum[7:4], bit'($urandom_range(1)));
		chars[25] = hex_char(sum[3:0], bit'($urandom_range(1)));
		if ($urandom_range(99) < 12) begin
			repeat ($urandom_range(1, 2))
				chars[$urandom_range(FRAME_CHARS - 1)] = random_non_hex();
		end
		cut = ($urandom_range(99) < 8) ? $urandom_range(1, FRAME_CHARS - 1) : FRAME_CHARS;
		for (int i = 0; i < cut; i++) push_word(1'b0, chars[i]);
		if (cut < FRAME_CHARS) push_word(1'b1, 8'($urandom_range(255)));
	endtask

	// Sender: presents queued words at the falling edge with random gaps.
	int send_gap = 0;
	int send_burst = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (s_axis_tvalid && !in_taken) begin
			// Hold the word until it is taken.
		end else if (send_gap > 0) begin
			s_axis_tvalid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (char_queue.size() > 0) begin
			item_t it;
			it = char_queue.pop_front();
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= it.rx_byte;
			s_axis_tuser <= it.restart;
			if (send_burst > 0) begin
				send_burst <= send_burst - 1;
				send_gap <= 0;
			end else if ($urandom_range(99) < 3) begin
				send_burst <= $urandom_range(30, 90);
				send_gap <= 0;
			end else begin
				case ($urandom_range(99)) inside
					[0:54]: send_gap <= 0;
					[55:94]: send_gap <= $urandom_range(1, 3);
					default: send_gap <= $urandom_range(8, 40);
				endcase
			end
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// Receiver: random stalls, plus one long hold-off that backs up the input.
	int  rx_hold = 0;
	bit  hold_done = 1'b0;
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (rx_hold > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else if (!hold_done && frames_seen >= 12) begin
			m_axis_tready <= 1'b0;
			rx_hold <= HOLD_TICKS;
			hold_done <= 1'b1;
		end else if ($urandom_range(99) < 12) begin
			m_axis_tready <= 1'b0;
			rx_hold <= ($urandom_range(19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Monitor: checks result words and feeds accepted words to the decoder.
	always @(posedge clk) begin : monitor
		frame_rec_t want;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= s_axis_tvalid && s_axis_tready;
			if (m_axis_tvalid && m_axis_tready) begin
				frames_seen <= frames_seen + 1;
				if (frames_due.size() == 0) begin
					$error("result word with no frame pending, frame_status %0d", m_axis_tuser);
					error_count++;
				end else begin
					want = frames_due.pop_front();
					for (int i = 0; i < NUM_READINGS; i++) begin
						if (m_axis_tdata[16 * i +: 16] !== want.readings[i]) begin
							$error("%s: expected %h, got %h", zone_name[i],
								want.readings[i], m_axis_tdata[16 * i +: 16]);
							error_count++;
						end
					end
					if (m_axis_tuser !== want.status) begin
						$error("frame_status: expected %0d, got %0d", want.status, m_axis_tuser);
						error_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				deframe_char(s_axis_tuser[0], s_axis_tdata);
				words_taken <= words_taken + 1;
			end
		end
	end

	// Watchdog on cycles with no word moving on either side.
	int idle_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin : stimulus
		int total;
		// Restarts alone, with the byte at both extremes.
		push_word(1'b1, 8'hff);
		push_word(1'b1, 8'h00);
		// All zero readings, good checksum.
		push_text("0000000000");
		push_text("0000000000");
		push_text("000000");
		// All ones in lower case; twelve 0xff bytes cancel out.
		push_text("ffffffffff");
		push_text("ffffffffff");
		push_text("ffff00");
		// Every digit in both cases, good checksum.
		push_text("0123456789ABCDEFabcdef0188");
		// Checksum mismatch.
		push_text("1234000000");
		push_text("0000000000");
		push_text("0000FF");
		// Characters just outside each digit range give the bad-character status.
		push_text("/:@G`g");
		push_text("0000000000");
		push_text("0000000000");
		// Partial frame dropped by a restart, then a good frame.
		push_text("ABCD12");
		push_word(1'b1, 8'h41);
		push_text("000100020003");
		push_text("00040005000607");
		// Non-hex character in the checksum digits together with a wrong checksum.
		push_text("0001");
		push_text("0000000000");
		push_text("0000000000");
		push_text("z9");

		while (char_queue.size() < CHAR_TARGET) begin
			if ($urandom_range(99) < 10) begin
				repeat ($urandom_range(1, 10)) push_word(1'b0, 8'($urandom_range(255)));
				push_word(1'b1, 8'($urandom_range(255)));
			end else begin
				push_random_frame();
			end
		end
		total = char_queue.size();

		repeat (RESET_TICKS) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (words_taken < total || frames_due.size() > 0) @(negedge clk);
		repeat (DRAIN_TICKS) @(negedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/core/hsd_pkg.sv
rtl/core/hsd_in_stage.sv
rtl/core/hsd_frame_core.sv
rtl/core/hex_sensor_frame_deframer.sv
rtl/core/hsd_checker.sv
sim/tb.sv
